### rtl/numa_home_node_balancer_top_defines.svh
// Assertion macros shared by the home node balancer RTL.
`ifndef NUMA_HOME_NODE_BALANCER_TOP_DEFINES_SVH
`define NUMA_HOME_NODE_BALANCER_TOP_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define NHNB_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define NHNB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/nhnb_pkg.sv
// Package: codes and defaults for the home node balancer.
package nhnb_pkg;
   localparam int MAX_TASKS_DEF = 128;
   localparam int MAX_NODES_DEF = 8;

   localparam logic [1:0] ACT_REGISTER = 2'd0;
   localparam logic [1:0] ACT_FAULT    = 2'd1;
   localparam logic [1:0] ACT_QUERY    = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;

   localparam logic       REG_NODE_COUNT = 1'b0;
   localparam logic [3:0] NODE_COUNT_RST = 4'd1;
   localparam logic [6:0] MIGRATE_PCT_RST = 7'd70;

   localparam logic [9:0] EVAL_MASK = 10'h3FF;
   localparam logic [6:0] PCT_SCALE = 7'd100;
endpackage

### rtl/numa_home_node_balancer_top.sv
// Top level: task table, fault counters and home node migration sequencer.
// Per item: register clears the task's counter row one word a cycle; query scans table
// entries; fault scans entries, then bumps the counts; full table, empty table or unused
// action go straight to the response. Every 1024th fault of a task adds an evaluation walk
// over the nodes, and a row clear when the home moves. One item at a time; the result is
// valid as the block goes idle again. Reset empties the table and restores config.
module numa_home_node_balancer_top #(
   parameter int MAX_TASKS = nhnb_pkg::MAX_TASKS_DEF,
   parameter int MAX_NODES = nhnb_pkg::MAX_NODES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_task_id,
   input  logic [2:0]  req_requested_home,
   input  logic [2:0]  req_cpu_node,
   input  logic [2:0]  req_page_node,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_home,
   output logic        rsp_migrated,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import nhnb_pkg::*;
   `include "numa_home_node_balancer_top_defines.svh"

   localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int UW = $clog2(MAX_TASKS + 1);
   localparam int NW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int RDEPTH = MAX_TASKS << NW;
   localparam int SW = 32 + NW;
   localparam int PW = SW + 8;
   localparam int XW = 5;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CLR  = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_CMP  = 4'd3;
   localparam logic [3:0] S_INC  = 4'd4;
   localparam logic [3:0] S_ERD  = 4'd5;
   localparam logic [3:0] S_EACC = 4'd6;
   localparam logic [3:0] S_PROD = 4'd7;
   localparam logic [3:0] S_DEC  = 4'd8;
   localparam logic [3:0] S_MCLR = 4'd9;
   localparam logic [3:0] S_RESP = 4'd10;

   // Configuration registers.
   logic [3:0] node_count_ff, node_count_in;
   logic [6:0] pct_ff, pct_in;
   logic       csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_NODE_COUNT) ? {28'd0, node_count_ff}
                                                        : {25'd0, pct_ff};
   always_comb begin
      node_count_in = node_count_ff;
      pct_in = pct_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_NODE_COUNT) node_count_in = csr_pwdata[3:0];
         else pct_in = csr_pwdata[6:0];
      end
   end

   // Effective node count: min(node_count, MAX_NODES).
   logic [CW-1:0] nodes_eff;
   assign nodes_eff = (XW'(node_count_ff) >= XW'(MAX_NODES)) ? CW'(MAX_NODES)
                                                             : CW'(node_count_ff);

   // Memories.
   logic [31:0] tid_mem  [MAX_TASKS];
   logic [2:0]  home_mem [MAX_TASKS];
   logic [31:0] tot_mem  [MAX_TASKS];
   logic [31:0] rem_mem  [RDEPTH];

   logic          tab_re, tid_we, home_we, tot_we, rem_re, rem_we;
   logic [TW-1:0] tab_raddr, tab_waddr;
   logic [TW+NW-1:0] rem_raddr, rem_waddr;
   logic [31:0]   tid_wd, tot_wd, rem_wd;
   logic [2:0]    home_wd;
   logic [31:0]   tid_rd_ff, tot_rd_ff, rem_rd_ff;
   logic [2:0]    home_rd_ff;

   always_ff @(posedge clock) begin
      if (tid_we)  tid_mem[tab_waddr] <= tid_wd;
      if (home_we) home_mem[tab_waddr] <= home_wd;
      if (tot_we)  tot_mem[tab_waddr] <= tot_wd;
      if (tab_re) begin
         tid_rd_ff  <= tid_mem[tab_raddr];
         home_rd_ff <= home_mem[tab_raddr];
         tot_rd_ff  <= tot_mem[tab_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (rem_we) rem_mem[rem_waddr] <= rem_wd;
      if (rem_re) rem_rd_ff <= rem_mem[rem_raddr];
   end

   // Sequencer state.
   logic [3:0]    state_ff, state_in;
   logic [1:0]    act_ff, act_in;
   logic [31:0]   id_ff, id_in;
   logic [2:0]    cpu_ff, cpu_in, page_ff, page_in;
   logic [UW-1:0] used_ff, used_in, idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in, best_ff, best_in;
   logic [TW-1:0] slot_ff, slot_in;
   logic [2:0]    home_ff, home_in;
   logic [31:0]   tot_ff, tot_in, bestc_ff, bestc_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [PW-1:0] proda_ff, proda_in, prodb_ff, prodb_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [2:0]    res_home_ff, res_home_in;
   logic          res_mig_ff, res_mig_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [2:0]    rsp_home_ff, rsp_home_in;
   logic          rsp_mig_ff, rsp_mig_in;

   logic          req_take, counted, last_node;
   logic [31:0]   tot_new, tot_div;
   logic [NW-1:0] page_idx;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign page_idx  = NW'(page_ff);
   assign counted   = (cpu_ff != page_ff) && (XW'(page_ff) < XW'(MAX_NODES));
   assign tot_new   = tot_ff + 32'd1;
   assign tot_div   = (tot_ff == 32'd0) ? 32'd1 : tot_ff;
   assign last_node = (cnt_ff == CW'(MAX_NODES - 1));

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_home      = rsp_home_ff;
   assign rsp_migrated  = rsp_mig_ff;

   always_comb begin
      state_in = state_ff;
      act_in = act_ff; id_in = id_ff; cpu_in = cpu_ff; page_in = page_ff;
      used_in = used_ff; idx_in = idx_ff; cnt_in = cnt_ff; best_in = best_ff;
      slot_in = slot_ff; home_in = home_ff; tot_in = tot_ff; bestc_in = bestc_ff;
      sum_in = sum_ff; proda_in = proda_ff; prodb_in = prodb_ff;
      res_status_in = res_status_ff; res_home_in = res_home_ff; res_mig_in = res_mig_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff; rsp_home_in = rsp_home_ff; rsp_mig_in = rsp_mig_ff;
      tab_re = 1'b0; tab_raddr = idx_ff[TW-1:0];
      tid_we = 1'b0; home_we = 1'b0; tot_we = 1'b0; tab_waddr = slot_ff;
      tid_wd = id_ff; home_wd = home_ff; tot_wd = 32'd0;
      rem_re = 1'b0; rem_raddr = {idx_ff[TW-1:0], page_idx};
      rem_we = 1'b0; rem_waddr = {slot_ff, cnt_ff[NW-1:0]}; rem_wd = 32'd0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               act_in = req_action; id_in = req_task_id;
               cpu_in = req_cpu_node; page_in = req_page_node;
               res_status_in = ST_OK; res_home_in = 3'd0; res_mig_in = 1'b0;
               idx_in = '0; cnt_in = '0;
               case (req_action)
                  ACT_REGISTER: begin
                     if (used_ff >= UW'(MAX_TASKS)) begin
                        res_status_in = ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        slot_in = used_ff[TW-1:0];
                        // Clamp a home outside the nodes in use to node 0.
                        home_in = (XW'(req_requested_home) >= XW'(nodes_eff)) ? 3'd0
                                                                              : req_requested_home;
                        state_in = S_CLR;
                     end
                  end
                  ACT_FAULT, ACT_QUERY: begin
                     if (used_ff == '0) begin
                        res_status_in = ST_UNKNOWN;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_CLR: begin
            rem_we = 1'b1;
            if (cnt_ff == '0) begin
               tid_we = 1'b1; home_we = 1'b1; tot_we = 1'b1;
            end
            cnt_in = cnt_ff + CW'(1);
            if (last_node) begin
               used_in = used_ff + UW'(1);
               res_home_in = home_ff;
               state_in = S_RESP;
            end
         end
         S_RD: begin
            tab_re = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (tid_rd_ff == id_ff) begin
               slot_in = idx_ff[TW-1:0];
               home_in = home_rd_ff;
               tot_in = tot_rd_ff;
               if (act_ff == ACT_QUERY) begin
                  res_home_in = home_rd_ff;
                  state_in = S_RESP;
               end else begin
                  rem_re = 1'b1;
                  state_in = S_INC;
               end
            end else if (idx_ff + UW'(1) == used_ff) begin
               res_status_in = ST_UNKNOWN;
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff + UW'(1);
               state_in = S_RD;
            end
         end
         S_INC: begin
            tot_we = 1'b1; tot_wd = tot_new;
            tot_in = tot_new;
            if (counted) begin
               rem_we = 1'b1;
               rem_waddr = {slot_ff, page_idx};
               rem_wd = rem_rd_ff + 32'd1;
            end
            if ((tot_new[9:0] & EVAL_MASK) == 10'd0) begin
               cnt_in = '0; sum_in = '0; best_in = CW'(home_ff); bestc_in = '0;
               state_in = S_ERD;
            end else begin
               res_home_in = home_ff;
               state_in = S_RESP;
            end
         end
         S_ERD: begin
            if (cnt_ff >= nodes_eff) begin
               state_in = S_PROD;
            end else begin
               rem_re = 1'b1;
               rem_raddr = {slot_ff, cnt_ff[NW-1:0]};
               state_in = S_EACC;
            end
         end
         S_EACC: begin
            if (XW'(cnt_ff) != XW'(home_ff)) begin
               sum_in = sum_ff + SW'(rem_rd_ff);
               if (rem_rd_ff > bestc_ff) begin
                  bestc_in = rem_rd_ff;
                  best_in = cnt_ff;
               end
            end
            cnt_in = cnt_ff + CW'(1);
            state_in = S_ERD;
         end
         S_PROD: begin
            // floor(sum*100/total) > pct  <=>  sum*100 >= (pct+1)*total
            proda_in = PW'(sum_ff) * PW'(PCT_SCALE);
            prodb_in = PW'({1'b0, pct_ff} + 8'd1) * PW'(tot_div);
            state_in = S_DEC;
         end
         S_DEC: begin
            if ((proda_ff >= prodb_ff) && (bestc_ff != 32'd0)) begin
               home_we = 1'b1; home_wd = 3'(best_ff);
               tot_we = 1'b1; tot_wd = 32'd0;
               home_in = 3'(best_ff);
               res_home_in = 3'(best_ff);
               res_mig_in = 1'b1;
               cnt_in = '0;
               state_in = S_MCLR;
            end else begin
               res_home_in = home_ff;
               state_in = S_RESP;
            end
         end
         S_MCLR: begin
            rem_we = 1'b1;
            cnt_in = cnt_ff + CW'(1);
            if (last_node) state_in = S_RESP;
         end
         S_RESP: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_home_in = res_home_ff;
               rsp_mig_in = res_mig_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
         node_count_ff <= NODE_COUNT_RST;
         pct_ff <= MIGRATE_PCT_RST;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         node_count_ff <= node_count_in;
         pct_ff <= pct_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in; id_ff <= id_in; cpu_ff <= cpu_in; page_ff <= page_in;
      idx_ff <= idx_in; cnt_ff <= cnt_in; best_ff <= best_in;
      slot_ff <= slot_in; home_ff <= home_in; tot_ff <= tot_in; bestc_ff <= bestc_in;
      sum_ff <= sum_in; proda_ff <= proda_in; prodb_ff <= prodb_in;
      res_status_ff <= res_status_in; res_home_ff <= res_home_in; res_mig_ff <= res_mig_in;
      rsp_status_ff <= rsp_status_in; rsp_home_ff <= rsp_home_in; rsp_mig_ff <= rsp_mig_in;
   end

   `NHNB_ASSERT_NEXT(a_take_leaves_idle, req_take, state_ff != S_IDLE, "item taken but still idle")
   `NHNB_ASSERT_IMPL(a_used_bound, 1'b1, used_ff <= UW'(MAX_TASKS), "task count past table size")
   `NHNB_ASSERT_IMPL(a_mig_ok, rsp_valid_ff && rsp_mig_ff, rsp_status_ff == ST_OK, "move with bad status")
   `NHNB_ASSERT_NEXT(a_used_step, state_ff != S_CLR, used_ff == $past(used_ff), "task count moved outside registration")
endmodule
